>>> rtl/min_tracking_stack_macros.svh
// Assertion macros shared by the min tracking stack checker.
// No dependencies; include by bare file name.
`ifndef MIN_TRACKING_STACK_MACROS_SVH
`define MIN_TRACKING_STACK_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define MTS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("min tracking stack: check failed");

// Next-cycle implication, disabled while reset is asserted
`define MTS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("min tracking stack: check failed");

`endif

>>> rtl/mts_pkg.sv
// Package for the min tracking stack: transaction structs, op and status codes,
// and the control/status structs between controller and datapath. No dependencies.
package mts_pkg;

    // Operation codes; the spare code behaves as a peek
    typedef enum logic [1:0] {
        OP_PEEK  = 2'd0,
        OP_PUSH  = 2'd1,
        OP_POP   = 2'd2,
        OP_SPARE = 2'd3
    } t_op;

    // Result status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_PUSH_FULL = 2'd1;
    localparam logic [1:0] ST_POP_EMPTY = 2'd2;

    typedef struct packed {
        logic [1:0]         op;
        logic signed [31:0] value;
    } t_cmd;

    typedef struct packed {
        logic signed [31:0] top_value;
        logic signed [31:0] min_value;
        logic               is_empty;
        logic [1:0]         status;
    } t_result;

    // Controller to datapath commands
    typedef struct packed {
        logic exec;   // transaction accepted this cycle
        logic load;   // reload top caches from memory read data
    } t_dp_ctl;

    // Datapath to controller status
    typedef struct packed {
        logic need_rd; // accepted op is a legal pop: needs a memory read
    } t_dp_stat;

endpackage

>>> rtl/mts_datapath.sv
// Datapath of the min tracking stack: value and minima memories, counts,
// cached top entries and the result register. Depends on mts_pkg.
module mts_datapath
    import mts_pkg::*;
#(
    parameter int STACK_DEPTH = 128
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_dp_ctl  i_ctl,
    input  t_cmd     i_cmd,
    output t_dp_stat o_stat,
    output t_result  o_result
);
    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(STACK_DEPTH);
    localparam logic [CW-1:0] ONE = CW'(1);
    localparam logic [CW-1:0] TWO = CW'(2);

    logic signed [31:0] r_val_mem [STACK_DEPTH];
    logic signed [31:0] r_min_mem [STACK_DEPTH];

    logic [CW-1:0]      r_val_cnt, r_min_cnt;
    logic signed [31:0] r_top, r_min;
    logic signed [31:0] r_rd_val, r_rd_min;
    logic               r_pop_min;
    logic [1:0]         r_status;

    logic          is_push, is_pop, full, empty, push_ok, pop_ok, push_min, pop_min;
    logic [CW-1:0] val_below, min_below;

    // Decode the transaction against the current stack state
    assign is_push  = (t_op'(i_cmd.op) == OP_PUSH);
    assign is_pop   = (t_op'(i_cmd.op) == OP_POP);
    assign full     = (r_val_cnt == FULL_CNT);
    assign empty    = (r_val_cnt == '0);
    assign push_ok  = is_push && !full;
    assign pop_ok   = is_pop && !empty;
    assign push_min = (r_min_cnt == '0) || (r_min >= i_cmd.value);
    assign pop_min  = (r_min_cnt != '0) && (r_top == r_min);
    assign val_below = r_val_cnt - TWO;
    assign min_below = r_min_cnt - TWO;

    assign o_stat.need_rd = pop_ok;

    // Memory writes on push
    always_ff @(posedge i_clk) begin
        if (i_ctl.exec && push_ok) begin
            r_val_mem[r_val_cnt[AW-1:0]] <= i_cmd.value;
            if (push_min) begin
                r_min_mem[r_min_cnt[AW-1:0]] <= i_cmd.value;
            end
        end
    end

    // Registered reads of the entries just below the tops
    always_ff @(posedge i_clk) begin
        r_rd_val <= r_val_mem[val_below[AW-1:0]];
        r_rd_min <= r_min_mem[min_below[AW-1:0]];
    end

    // Counts
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_val_cnt <= '0;
            r_min_cnt <= '0;
        end else if (i_ctl.exec) begin
            if (push_ok) begin
                r_val_cnt <= r_val_cnt + ONE;
                if (push_min) begin
                    r_min_cnt <= r_min_cnt + ONE;
                end
            end else if (pop_ok) begin
                r_val_cnt <= r_val_cnt - ONE;
                if (pop_min) begin
                    r_min_cnt <= r_min_cnt - ONE;
                end
            end
        end
    end

    // Cached tops and result status
    always_ff @(posedge i_clk) begin
        if (i_ctl.exec) begin
            r_pop_min <= pop_min;
            if (push_ok) begin
                r_top <= i_cmd.value;
                if (push_min) begin
                    r_min <= i_cmd.value;
                end
            end
            if (is_push && full) begin
                r_status <= ST_PUSH_FULL;
            end else if (is_pop && empty) begin
                r_status <= ST_POP_EMPTY;
            end else begin
                r_status <= ST_OK;
            end
        end else if (i_ctl.load) begin
            r_top <= r_rd_val;
            if (r_pop_min) begin
                r_min <= r_rd_min;
            end
        end
    end

    // Result: tops read as zero while empty
    assign o_result.is_empty  = empty;
    assign o_result.top_value = empty ? '0 : r_top;
    assign o_result.min_value = empty ? '0 : r_min;
    assign o_result.status    = r_status;

endmodule

>>> rtl/mts_ctrl.sv
// Controller of the min tracking stack: sequences accept, memory reload and
// the result strobe. Depends on mts_pkg.
module mts_ctrl
    import mts_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_start,
    input  t_dp_stat i_stat,
    output t_dp_ctl  o_ctl,
    output logic     o_busy,
    output logic     o_done
);
    typedef enum logic [1:0] {
        S_IDLE,
        S_LOAD,
        S_RESP
    } t_state;

    t_state r_state;
    logic   r_busy, r_done;
    logic   accept;

    assign accept     = i_start && !r_busy;
    assign o_ctl.exec = accept;
    assign o_ctl.load = (r_state == S_LOAD);
    assign o_busy     = r_busy;
    assign o_done     = r_done;

    // State and registered handshake outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_busy  <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_busy <= 1'b1;
                        if (i_stat.need_rd) begin
                            r_state <= S_LOAD;
                        end else begin
                            r_state <= S_RESP;
                            r_done  <= 1'b1;
                        end
                    end
                end
                S_LOAD: begin
                    r_state <= S_RESP;
                    r_done  <= 1'b1;
                end
                S_RESP: begin
                    r_state <= S_IDLE;
                    r_done  <= 1'b0;
                    r_busy  <= 1'b0;
                end
                default: begin
                    r_state <= S_IDLE;
                    r_done  <= 1'b0;
                    r_busy  <= 1'b0;
                end
            endcase
        end
    end

endmodule

>>> rtl/min_tracking_stack.sv
// Min tracking stack: peek/push/pop with running minimum, one result per transaction.
// Result strobe in the cycle after accept for peek/push/refused ops; a legal pop
// passes S_LOAD first (memory read reloads the tops). No accept until the strobe ends.
// Busy is high from accept until the strobe cycle ends; the receiver cannot stall.
// Synchronous active-low reset empties both stacks; no memory clearing is needed.
// Depends on mts_pkg, mts_ctrl and mts_datapath.
module min_tracking_stack
    import mts_pkg::*;
#(
    parameter int STACK_DEPTH = 128
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_start,
    input  t_cmd    i_cmd,
    output logic    o_busy,
    output logic    o_done,
    output t_result o_result
);
    t_dp_ctl  dp_ctl;
    t_dp_stat dp_stat;

    mts_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .i_stat  (dp_stat),
        .o_ctl   (dp_ctl),
        .o_busy  (o_busy),
        .o_done  (o_done)
    );

    mts_datapath #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (dp_ctl),
        .i_cmd    (i_cmd),
        .o_stat   (dp_stat),
        .o_result (o_result)
    );

endmodule

>>> rtl/mts_checker.sv
// Port-level checker for the min tracking stack, bound to the top level.
// Depends on mts_pkg and min_tracking_stack_macros.svh.
`include "min_tracking_stack_macros.svh"

module mts_checker
    import mts_pkg::*;
(
    input logic    i_clk,
    input logic    i_rst_n,
    input logic    i_start,
    input logic    o_busy,
    input logic    o_done,
    input t_result o_result
);
    logic accept;
    assign accept = i_start && !o_busy;

    // An accepted transaction holds off the next one
    `MTS_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, accept, o_busy)
    // Results only appear inside a busy window
    `MTS_ASSERT_NOW(a_done_in_busy, i_clk, i_rst_n, o_done, o_busy)
    // One strobe per transaction
    `MTS_ASSERT_NEXT(a_done_single, i_clk, i_rst_n, o_done, !o_done)
    // Empty stack reads zero for both tops
    `MTS_ASSERT_NOW(a_empty_zero, i_clk, i_rst_n, o_done && o_result.is_empty,
        (o_result.top_value == 0) && (o_result.min_value == 0))
    // A refused pop leaves the stack empty
    `MTS_ASSERT_NOW(a_pop_refused, i_clk, i_rst_n,
        o_done && (o_result.status == ST_POP_EMPTY), o_result.is_empty)

endmodule

bind min_tracking_stack mts_checker u_mts_checker (.*);

>>> verif/mts_scoreboard_pkg.sv
`timescale 1ns / 100ps
// Scoreboard for the min tracking stack: predicts one result per command.
// Depends on mts_pkg for the command/result structs and the op and status codes.
package mts_scoreboard_pkg;
    import mts_pkg::*;

    class stack_scoreboard;
        int unsigned        depth;
        logic signed [31:0] entries[$];
        logic signed [31:0] minima[$];
        t_result            due[$];
        int                 errors;

        function new(int unsigned stack_depth);
            depth  = stack_depth;
            errors = 0;
        endfunction

        function int pending();
            return due.size();
        endfunction

        // Apply an accepted command to the shadow stacks and queue its result
        function void note_command(t_cmd cmd);
            t_result            res;
            logic signed [31:0] v;
            logic               now_empty;
            v          = cmd.value;
            res.status = ST_OK;
            case (t_op'(cmd.op))
                OP_PUSH: begin
                    if (entries.size() >= depth) begin
                        res.status = ST_PUSH_FULL;
                    end else begin
                        // ties go onto the minima stack too
                        if (minima.size() == 0 || minima[$] >= v)
                            minima.push_back(v);
                        entries.push_back(v);
                    end
                end
                OP_POP: begin
                    if (entries.size() == 0) begin
                        res.status = ST_POP_EMPTY;
                    end else begin
                        if (minima.size() > 0 && entries[$] == minima[$])
                            void'(minima.pop_back());
                        void'(entries.pop_back());
                    end
                end
                default: ;  // peek and the spare code change nothing
            endcase
            now_empty     = (entries.size() == 0);
            res.is_empty  = now_empty;
            res.top_value = now_empty ? 32'sd0 : entries[$];
            res.min_value = (!now_empty && minima.size() > 0) ? minima[$] : 32'sd0;
            due.push_back(res);
        endfunction

        // Compare a strobed result with the oldest prediction
        function void check_result(t_result got);
            t_result exp;
            if (due.size() == 0) begin
                $error("result with nothing outstanding: top %0d min %0d empty %0b status %0d",
                       got.top_value, got.min_value, got.is_empty, got.status);
                errors++;
                return;
            end
            exp = due.pop_front();
            if (got.top_value !== exp.top_value) begin
                $error("top_value: expected %0d, got %0d", exp.top_value, got.top_value);
                errors++;
            end
            if (got.min_value !== exp.min_value) begin
                $error("min_value: expected %0d, got %0d", exp.min_value, got.min_value);
                errors++;
            end
            if (got.is_empty !== exp.is_empty) begin
                $error("is_empty: expected %0b, got %0b", exp.is_empty, got.is_empty);
                errors++;
            end
            if (got.status !== exp.status) begin
                $error("status: expected %0d, got %0d", exp.status, got.status);
                errors++;
            end
        endfunction
    endclass

endpackage

>>> verif/tb.sv
`timescale 1ns / 100ps
// Top-level testbench for min_tracking_stack: directed then random push/pop/peek traffic.
// Depends on mts_pkg, mts_scoreboard_pkg and the min_tracking_stack RTL.
module tb;
    import mts_pkg::*;
    import mts_scoreboard_pkg::*;

    localparam int DEPTH       = 128;
    localparam int PHASE_ITEMS = 535;
    localparam int QUIET_LIMIT = 2000;
    localparam int DRAIN_WAIT  = 10;

    logic    i_clk;
    logic    i_rst_n;
    logic    i_start;
    t_cmd    i_cmd;
    logic    o_busy;
    logic    o_done;
    t_result o_result;

    stack_scoreboard stack_sb;
    int              idle_pct;
    int              quiet_cycles;

    min_tracking_stack #(
        .STACK_DEPTH(DEPTH)
    ) dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_start),
        .i_cmd    (i_cmd),
        .o_busy   (o_busy),
        .o_done   (o_done),
        .o_result (o_result)
    );

    // 8 ns clock
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Monitor: results first, then the accepted command, both on the rising edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_done)
                stack_sb.check_result(o_result);
            if (i_start && !o_busy)
                stack_sb.note_command(i_cmd);
        end
    end

    // Watchdog on cycles without any accepted transaction or result strobe
    always @(posedge i_clk) begin
        if (!i_rst_n || o_done || (i_start && !o_busy)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("tb: errors");
            $finish;
        end
    end

    // Present one command from a falling edge and hold it until accepted
    task automatic send_cmd(input t_op op, input logic [31:0] val);
        t_cmd cmd;
        cmd.op    = op;
        cmd.value = val;
        while ($urandom_range(0, 99) < idle_pct) begin
            i_start <= 1'b0;
            @(negedge i_clk);
        end
        i_start <= 1'b1;
        i_cmd   <= cmd;
        @(posedge i_clk);
        while (o_busy) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Sender holds off until every predicted result has been seen
    task automatic drain();
        i_start <= 1'b0;
        @(negedge i_clk);
        while (stack_sb.pending() != 0) @(negedge i_clk);
    endtask

    // Mix of extremes, small values (for ties on the minimum) and full-range values
    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 9))
            0: begin
                case ($urandom_range(0, 3))
                    0: return 32'h8000_0000;
                    1: return 32'h7FFF_FFFF;
                    2: return 32'h0000_0000;
                    default: return 32'hFFFF_FFFF;
                endcase
            end
            1, 2, 3, 4, 5: return 32'($signed($urandom_range(0, 16)) - 8);
            default: return $urandom;
        endcase
    endfunction

    // Runs of push-heavy, pop-heavy or balanced traffic so both full and empty are hit
    task automatic random_phase(input int n_items);
        int sent;
        int run_len;
        int push_pct;
        int r;
        sent = 0;
        while (sent < n_items) begin
            case ($urandom_range(0, 2))
                0: push_pct = 85;
                1: push_pct = 15;
                default: push_pct = 50;
            endcase
            run_len = $urandom_range(20, 200);
            for (int k = 0; k < run_len && sent < n_items; k++) begin
                r = $urandom_range(0, 99);
                if (r < push_pct)
                    send_cmd(OP_PUSH, pick_value());
                else if ($urandom_range(0, 9) != 0)
                    send_cmd(OP_POP, $urandom);
                else if ($urandom_range(0, 1) != 0)
                    send_cmd(OP_PEEK, $urandom);
                else
                    send_cmd(OP_SPARE, $urandom);
                sent++;
            end
        end
    endtask

    // Stimulus
    initial begin
        stack_sb = new(DEPTH);
        idle_pct = 0;
        i_rst_n  = 1'b0;
        i_start  = 1'b0;
        i_cmd    = '0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: empty-stack cases, extremes, ties on the minimum, ignored value fields
        send_cmd(OP_PEEK,  32'h0000_0000);
        send_cmd(OP_POP,   32'hFFFF_FFFF);
        send_cmd(OP_SPARE, 32'h1234_5678);
        send_cmd(OP_PUSH,  32'd5);
        send_cmd(OP_PUSH,  32'd7);
        send_cmd(OP_PUSH,  32'd5);
        send_cmd(OP_PUSH,  32'h8000_0000);
        send_cmd(OP_PUSH,  32'h7FFF_FFFF);
        send_cmd(OP_SPARE, 32'hFFFF_FFFF);
        send_cmd(OP_POP,   32'h0000_0000);
        send_cmd(OP_POP,   32'h8000_0000);
        send_cmd(OP_POP,   32'h7FFF_FFFF);
        send_cmd(OP_PEEK,  32'h8000_0000);
        send_cmd(OP_POP,   32'd0);
        send_cmd(OP_POP,   32'd0);
        send_cmd(OP_POP,   32'd0);
        send_cmd(OP_PUSH,  32'hFFFF_FFFF);
        send_cmd(OP_PUSH,  32'h0000_0000);
        send_cmd(OP_PUSH,  32'h8000_0000);
        send_cmd(OP_PUSH,  32'h8000_0000);
        send_cmd(OP_POP,   32'd0);
        send_cmd(OP_PEEK,  32'd0);
        drain();

        // random: light sender gaps, then heavy gaps, then back to back
        idle_pct = 8;
        random_phase(PHASE_ITEMS);
        drain();
        idle_pct = 73;
        random_phase(PHASE_ITEMS);
        drain();
        idle_pct = 0;
        random_phase(PHASE_ITEMS);
        drain();

        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (stack_sb.errors == 0 && stack_sb.pending() == 0) begin
            $display("tb: clean");
        end else begin
            $display("tb: errors");
        end
        $finish;
    end

endmodule
